// ----- rtl/setq_pkg.sv -----
// setq_pkg: shared types, codes and default sizes for the sorted expiry timer queue.
// Used by the channel interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package setq_pkg;

   // default sizes handed to the top level parameters
   localparam int NUM_TIMERS_DEF = 8;
   localparam int TICK_BITS_DEF  = 32;

   // fixed field widths
   localparam int MODE_W    = 2;
   localparam int ID_W      = 3;
   localparam int TIMEOUT_W = 32;
   localparam int STATUS_W  = 2;
   localparam int MASK_W    = 8;

   // request modes (code 3 is unused)
   typedef enum logic [MODE_W-1:0] {
      MODE_START = 2'd0,
      MODE_STOP  = 2'd1,
      MODE_TICK  = 2'd2
   } mode_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_ACTIVE   = 2'd1,
      STAT_INACTIVE = 2'd2
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic latch_cmd;    // request transfer, capture payload
      logic status_load;  // capture response status of a start or stop
      logic start_arm;    // record period, compute expiry, begin insert walk
      logic do_stop;      // unlink the named timer
      logic tick_begin;   // advance now, snapshot list order, begin due walk
      logic scan_step;    // walk position forward by one slot
      logic ins_commit;   // link timer at the walk position
      logic fire_load;    // unlink next due timer, compute its reload expiry
      logic set_n;        // due count taken from walk position
      logic k_inc;        // next due timer
      logic out_resp;     // load a start/stop/idle-tick response
      logic out_fire;     // load a fire response
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      mode_type mode;
      logic     id_ok;
      logic     id_armed;
      logic     ins_more;
      logic     due_more;
      logic     pos_zero;
      logic     fire_periodic;
      logic     last_fire;
      logic     out_free;
   } stat_type;

endpackage

// ----- rtl/setq_req_if.sv -----
// setq_req_if: request channel (valid/ready plus mode, timer id and timeout).
// Depends on setq_pkg for field widths.
`timescale 1ns / 1ps

interface setq_req_if;
   logic                           valid;
   logic                           ready;
   logic [setq_pkg::MODE_W-1:0]    mode;
   logic [setq_pkg::ID_W-1:0]      timer_id;
   logic [setq_pkg::TIMEOUT_W-1:0] timeout;

   modport source (output valid, output mode, output timer_id, output timeout, input ready);
   modport sink   (input valid, input mode, input timer_id, input timeout, output ready);
endinterface

// ----- rtl/setq_rsp_if.sv -----
// setq_rsp_if: response channel (valid/ready plus status, fired, fired_timer, last).
// Depends on setq_pkg for field widths.
`timescale 1ns / 1ps

interface setq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [setq_pkg::STATUS_W-1:0] status;
   logic                          fired;
   logic [setq_pkg::ID_W-1:0]     fired_timer;
   logic                          last;

   modport source (output valid, output status, output fired, output fired_timer,
                   output last, input ready);
   modport sink   (input valid, input status, input fired, input fired_timer,
                   input last, output ready);
endinterface

// ----- rtl/setq_ctrl.sv -----
// setq_ctrl: one-hot sequencer for start, stop and tick requests.
// Depends on setq_pkg for command and status structs.
`timescale 1ns / 1ps

module setq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  setq_pkg::stat_type  stat,
   output setq_pkg::cmd_type   cmd
);

   typedef enum logic [7:0] {
      S_IDLE       = 8'b0000_0001,
      S_DISPATCH   = 8'b0000_0010,
      S_INS_SCAN   = 8'b0000_0100,
      S_INS_COMMIT = 8'b0000_1000,
      S_RESP       = 8'b0001_0000,
      S_TICK_SCAN  = 8'b0010_0000,
      S_FIRE_RM    = 8'b0100_0000,
      S_FIRE_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_cmd = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.status_load = 1'b1;
            case (stat.mode)
               setq_pkg::MODE_START: begin
                  if (stat.id_ok && !stat.id_armed) begin
                     cmd.start_arm = 1'b1;
                     state_in      = S_INS_SCAN;
                  end else begin
                     state_in = S_RESP;
                  end
               end
               setq_pkg::MODE_STOP: begin
                  cmd.do_stop = stat.id_ok && stat.id_armed;
                  state_in    = S_RESP;
               end
               setq_pkg::MODE_TICK: begin
                  cmd.tick_begin = 1'b1;
                  state_in       = S_TICK_SCAN;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_INS_SCAN: begin
            if (stat.ins_more) cmd.scan_step = 1'b1;
            else               state_in = S_INS_COMMIT;
         end
         S_INS_COMMIT: begin
            cmd.ins_commit = 1'b1;
            state_in = (stat.mode == setq_pkg::MODE_TICK) ? S_FIRE_OUT : S_RESP;
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.out_resp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_TICK_SCAN: begin
            if (stat.due_more) begin
               cmd.scan_step = 1'b1;
            end else begin
               cmd.set_n = 1'b1;
               state_in  = stat.pos_zero ? S_RESP : S_FIRE_RM;
            end
         end
         S_FIRE_RM: begin
            cmd.fire_load = 1'b1;
            state_in = stat.fire_periodic ? S_INS_SCAN : S_FIRE_OUT;
         end
         S_FIRE_OUT: begin
            if (stat.out_free) begin
               cmd.out_fire = 1'b1;
               if (stat.last_fire) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.k_inc = 1'b1;
                  state_in  = S_FIRE_RM;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- rtl/setq_dp.sv -----
// setq_dp: timer list, periods, tick counter, walk counters and response register.
// Depends on setq_pkg; driven by setq_ctrl commands.
`timescale 1ns / 1ps

module setq_dp #(
   parameter int NUM_TIMERS = setq_pkg::NUM_TIMERS_DEF,
   parameter int TICK_BITS  = setq_pkg::TICK_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  setq_pkg::cmd_type                cmd,
   output setq_pkg::stat_type               stat,
   input  logic [setq_pkg::MODE_W-1:0]      req_mode,
   input  logic [setq_pkg::ID_W-1:0]        req_timer_id,
   input  logic [setq_pkg::TIMEOUT_W-1:0]   req_timeout,
   input  logic                             csr_wr_en,
   input  logic [setq_pkg::MASK_W-1:0]      csr_wr_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [setq_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_fired,
   output logic [setq_pkg::ID_W-1:0]        rsp_fired_timer,
   output logic                             rsp_last
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);

   // captured request
   setq_pkg::mode_type               mode_ff;
   logic [setq_pkg::ID_W-1:0]        tid_ff;
   logic [setq_pkg::TIMEOUT_W-1:0]   timeout_ff;

   // timer state
   logic [NUM_TIMERS-1:0]  mask_ff;
   logic [TICK_BITS-1:0]   now_ff;
   logic [IDX_W-1:0]       lid_ff    [NUM_TIMERS];
   logic [IDX_W-1:0]       lid_in    [NUM_TIMERS];
   logic [TICK_BITS-1:0]   lexp_ff   [NUM_TIMERS];
   logic [TICK_BITS-1:0]   lexp_in   [NUM_TIMERS];
   logic [TICK_BITS-1:0]   period_ff [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]  armed_ff, armed_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   // walk state
   logic [IDX_W-1:0]       due_ff [NUM_TIMERS];
   logic [IDX_W-1:0]       cur_id_ff;
   logic [TICK_BITS-1:0]   ins_exp_ff;
   logic [CNT_W-1:0]       pos_ff;
   logic [CNT_W-1:0]       n_ff;
   logic [CNT_W-1:0]       k_ff;
   setq_pkg::status_type   status_ff;

   // response register
   logic                          rsp_valid_ff;
   logic [setq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                          rsp_fired_ff;
   logic [setq_pkg::ID_W-1:0]     rsp_tid_ff;
   logic                          rsp_last_ff;

   logic [IDX_W-1:0]       tid_idx, fire_id, rm_id;
   logic                   tid_ok, id_armed, pos_in_list;
   logic [TICK_BITS-1:0]   head_exp;
   setq_pkg::status_type   status_in;
   logic [NUM_TIMERS-1:0]  rm_match, rm_after;

   // lookups
   assign tid_ok      = (int'(tid_ff) < NUM_TIMERS);
   assign tid_idx     = tid_ff[IDX_W-1:0];
   assign id_armed    = tid_ok && armed_ff[tid_idx];
   assign pos_in_list = (pos_ff < count_ff);
   assign head_exp    = lexp_ff[pos_ff[IDX_W-1:0]];
   assign fire_id     = due_ff[k_ff[IDX_W-1:0]];
   assign rm_id       = cmd.do_stop ? tid_idx : fire_id;

   assign stat.mode          = mode_ff;
   assign stat.id_ok         = tid_ok;
   assign stat.id_armed      = id_armed;
   assign stat.ins_more      = pos_in_list && !(ins_exp_ff < head_exp);
   assign stat.due_more      = pos_in_list && (head_exp <= now_ff);
   assign stat.pos_zero      = (pos_ff == '0);
   assign stat.fire_periodic = mask_ff[fire_id];
   assign stat.last_fire     = ((k_ff + CNT_W'(1)) == n_ff);
   assign stat.out_free      = !rsp_valid_ff || rsp_ready;

   // response status of a start or stop
   always_comb begin
      status_in = setq_pkg::STAT_OK;
      case (mode_ff)
         setq_pkg::MODE_START: begin
            if (!tid_ok)       status_in = setq_pkg::STAT_INACTIVE;
            else if (id_armed) status_in = setq_pkg::STAT_ACTIVE;
         end
         setq_pkg::MODE_STOP: begin
            if (!id_armed) status_in = setq_pkg::STAT_INACTIVE;
         end
         default: status_in = setq_pkg::STAT_OK;
      endcase
   end

   // unlink match and prefix of slots that move down
   always_comb begin
      for (int j = 0; j < NUM_TIMERS; j++) begin
         rm_match[j] = (CNT_W'(j) < count_ff) && (lid_ff[j] == rm_id);
      end
      rm_after[0] = rm_match[0];
      for (int j = 1; j < NUM_TIMERS; j++) begin
         rm_after[j] = rm_after[j-1] | rm_match[j];
      end
   end

   // list update: unlink or sorted link at the walk position
   always_comb begin
      lid_in   = lid_ff;
      lexp_in  = lexp_ff;
      count_in = count_ff;
      armed_in = armed_ff;
      if (cmd.do_stop || cmd.fire_load) begin
         for (int j = 0; j < NUM_TIMERS - 1; j++) begin
            if (rm_after[j]) begin
               lid_in[j]  = lid_ff[j+1];
               lexp_in[j] = lexp_ff[j+1];
            end
         end
         if (rm_after[NUM_TIMERS-1]) count_in = count_ff - CNT_W'(1);
         armed_in[rm_id] = 1'b0;
      end else if (cmd.ins_commit) begin
         for (int j = 1; j < NUM_TIMERS; j++) begin
            if ((CNT_W'(j) > pos_ff) && (CNT_W'(j) <= count_ff)) begin
               lid_in[j]  = lid_ff[j-1];
               lexp_in[j] = lexp_ff[j-1];
            end
         end
         lid_in[pos_ff[IDX_W-1:0]]  = cur_id_ff;
         lexp_in[pos_ff[IDX_W-1:0]] = ins_exp_ff;
         count_in = count_ff + CNT_W'(1);
         armed_in[cur_id_ff] = 1'b1;
      end
   end

   // control state: tick, armed bits, count, mask
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff   <= '0;
         armed_ff <= '0;
         count_ff <= '0;
         mask_ff  <= '0;
      end else begin
         if (cmd.tick_begin) now_ff <= now_ff + TICK_BITS'(1);
         armed_ff <= armed_in;
         count_ff <= count_in;
         if (csr_wr_en) mask_ff <= csr_wr_data[NUM_TIMERS-1:0];
      end
   end

   // list payload, periods and walk registers
   always_ff @(posedge clock) begin
      lid_ff  <= lid_in;
      lexp_ff <= lexp_in;
      if (cmd.latch_cmd) begin
         mode_ff    <= setq_pkg::mode_type'(req_mode);
         tid_ff     <= req_timer_id;
         timeout_ff <= req_timeout;
      end
      if (cmd.status_load) status_ff <= status_in;
      if (cmd.start_arm) begin
         period_ff[tid_idx] <= TICK_BITS'(timeout_ff);
         ins_exp_ff         <= now_ff + TICK_BITS'(timeout_ff);
         cur_id_ff          <= tid_idx;
      end
      if (cmd.fire_load) begin
         ins_exp_ff <= now_ff + period_ff[fire_id];
         cur_id_ff  <= fire_id;
      end
      if (cmd.tick_begin) due_ff <= lid_ff;
      if (cmd.start_arm || cmd.tick_begin || cmd.fire_load) pos_ff <= '0;
      else if (cmd.scan_step)                               pos_ff <= pos_ff + CNT_W'(1);
      if (cmd.set_n) begin
         n_ff <= pos_ff;
         k_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + CNT_W'(1);
      end
   end

   // response register: valid cleared on transfer, reloaded by a command
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_resp || cmd.out_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_resp) begin
         rsp_status_ff <= status_ff;
         rsp_fired_ff  <= 1'b0;
         rsp_tid_ff    <= '0;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.out_fire) begin
         rsp_status_ff <= setq_pkg::STAT_OK;
         rsp_fired_ff  <= 1'b1;
         rsp_tid_ff    <= setq_pkg::ID_W'(cur_id_ff);
         rsp_last_ff   <= stat.last_fire;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_fired       = rsp_fired_ff;
   assign rsp_fired_timer = rsp_tid_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTH
   // list length matches the armed bits
   a_count_armed: assert property (@(posedge clock) disable iff (reset)
      $countones(armed_ff) == int'(count_ff))
      else $error("armed count does not match armed bits");

   // a link never goes into a full list
   a_no_full_insert: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_commit |-> (count_ff < CNT_W'(NUM_TIMERS)))
      else $error("insert into full timer list");

   // a pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_resp || cmd.out_fire) |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");

   // a stop unlinks exactly one timer
   a_stop_unlinks: assert property (@(posedge clock) disable iff (reset)
      cmd.do_stop |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("stop did not unlink one timer");
`endif

endmodule

// ----- rtl/sorted_expiry_timer_queue.sv -----
// Start: an accepted start walks the list to its sorted slot and links the timer before its response.
// Stop, rejected start, unused mode and idle tick each load a single response.
// Tick with D due timers: fires 1..D load in list order, each after its own unlink and, if periodic,
// after its sorted re-link; the walk in the datapath moves one slot per cycle.
// One request at a time; the next is taken in the cycle after the last response is loaded.
// Synchronous active-high reset: no timer armed, tick counter and mask cleared.
`timescale 1ns / 1ps

module sorted_expiry_timer_queue #(
   parameter int NUM_TIMERS = setq_pkg::NUM_TIMERS_DEF,
   parameter int TICK_BITS  = setq_pkg::TICK_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   setq_req_if.sink                      req_if,
   setq_rsp_if.source                    rsp_if,
   input  logic                          csr_wr_en,
   input  logic [setq_pkg::MASK_W-1:0]   csr_wr_data
);

   setq_pkg::cmd_type  cmd;
   setq_pkg::stat_type stat;

   // sequencer
   setq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // timer list and response register
   setq_dp #(
      .NUM_TIMERS (NUM_TIMERS),
      .TICK_BITS  (TICK_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_if.mode),
      .req_timer_id    (req_if.timer_id),
      .req_timeout     (req_if.timeout),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_status      (rsp_if.status),
      .rsp_fired       (rsp_if.fired),
      .rsp_fired_timer (rsp_if.fired_timer),
      .rsp_last        (rsp_if.last)
   );

endmodule
